// ===== sv/sdc_pkg.sv =====
// ---------------------------------------------------------------------------
// sdc_pkg: shared constants and types
// Geometry limits, widths, register indexes and pipeline metadata.
// ---------------------------------------------------------------------------
`default_nettype none
package sdc_pkg;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_DILATION = 7;
    localparam int ROW_SLOTS    = 2 * MAX_DILATION + 3;
    localparam int CHAIN_LEN    = ROW_SLOTS;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int SLOT_W       = $clog2(ROW_SLOTS);
    localparam int TAP_W        = $clog2(CHAIN_LEN);
    localparam int ADDR_W       = SLOT_W + COL_W;
    localparam int MEM_DEPTH    = ROW_SLOTS * MAX_WIDTH;
    localparam int COEF_W       = 16;
    localparam int PROD_W       = COEF_W + 9;
    localparam int SUM_W        = 28;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_STRIDE = 3'd2;
    localparam logic [2:0] CFG_DIL    = 3'd3;
    localparam logic [2:0] CFG_COEF0  = 3'd4;
    localparam logic [2:0] CFG_COEF1  = 3'd5;
    localparam logic [2:0] CFG_COEF2  = 3'd6;

    typedef struct packed {
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic             win;
        logic             last;
    } t_meta;
endpackage
`default_nettype wire

// ===== sv/sdc_cell.sv =====
// ---------------------------------------------------------------------------
// sdc_cell: one pixel cell of a window row
// Holds one pixel and passes it to its neighbor on each shift.
// ---------------------------------------------------------------------------
`default_nettype none
module sdc_cell
    import sdc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_shift,
    input  wire  [7:0] i_pix,
    output logic [7:0] o_pix
);
    logic [7:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;
endmodule
`default_nettype wire

// ===== sv/sdc_row.sv =====
// ---------------------------------------------------------------------------
// sdc_row: one kernel row
// Chain of pixel cells, three dilated taps, products and registered row sum.
// ---------------------------------------------------------------------------
`default_nettype none
module sdc_row
    import sdc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire                    i_shift,
    input  wire  [7:0]             i_pix,
    input  wire  [3:0]             i_step,
    input  wire  [3*COEF_W-1:0]    i_coef,
    output logic signed [SUM_W-1:0] o_sum
);
    logic [7:0] w_q [0:CHAIN_LEN-1];
    logic [TAP_W-1:0] w_idx1, w_idx2;
    logic [7:0] w_tap [0:2];
    logic signed [PROD_W-1:0] r_prod [0:2];
    logic signed [SUM_W-1:0]  r_sum;

    genvar g;
    generate
        for (g = 0; g < CHAIN_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                sdc_cell u_cell (.i_clk(i_clk), .i_shift(i_shift), .i_pix(i_pix),
                                 .o_pix(w_q[g]));
            end else begin : g_body
                sdc_cell u_cell (.i_clk(i_clk), .i_shift(i_shift), .i_pix(w_q[g-1]),
                                 .o_pix(w_q[g]));
            end
        end
    endgenerate

    // newest pixel is the right tap
    assign w_idx1   = TAP_W'(i_step);
    assign w_idx2   = TAP_W'({i_step, 1'b0});
    assign w_tap[2] = w_q[0];
    assign w_tap[1] = w_q[w_idx1];
    assign w_tap[0] = w_q[w_idx2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed(i_coef[COEF_W*k +: COEF_W])
                           * $signed({1'b0, w_tap[k]});
            end
            r_sum <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2]);
        end
    end

    assign o_sum = r_sum;
endmodule
`default_nettype wire

// ===== sv/strided_dilated_conv2d_top.sv =====
// ---------------------------------------------------------------------------
// strided_dilated_conv2d_top: streaming 3x3 dilated, strided valid correlation
// result word: valid only at window positions, carried from r_v1 to r_v6
// throughput: one pixel per cycle unless a held output stalls it, set by the
// single-write line memory and the cell chains that shift once per pixel
// reset: counters, phases, valids and config registers return to defaults; the
// line memory is not cleared, a window only reads rows of its own frame
// ---------------------------------------------------------------------------
`default_nettype none
module strided_dilated_conv2d_top
    import sdc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [47:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // pixel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_row, out_col, window_sum, pixel_out
    output logic        m_axis_tlast    // last
);
    // configuration
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [3:0]  r_stride;
    logic [2:0]  r_dil;
    logic [47:0] r_coef [0:2];
    logic        w_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
            r_stride <= 4'd1;
            r_dil    <= 3'd0;
            r_coef[0] <= '0;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width   <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[12:0];
                CFG_STRIDE: r_stride  <= i_cfg_data[3:0];
                CFG_DIL:    r_dil     <= i_cfg_data[2:0];
                CFG_COEF0:  r_coef[0] <= i_cfg_data;
                CFG_COEF1:  r_coef[1] <= i_cfg_data;
                CFG_COEF2:  r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_restart = i_cfg_we
                       && (i_cfg_idx inside {CFG_WIDTH, CFG_HEIGHT, CFG_STRIDE, CFG_DIL});

    // effective geometry
    logic [10:0] w_w;
    logic [12:0] w_h;
    logic [3:0]  w_s, w_step;
    logic [4:0]  w_span;

    always_comb begin
        w_w = (r_width < 11'd3) ? 11'd3 : (r_width > 11'd1024) ? 11'd1024 : r_width;
        w_h = (r_height < 13'd3) ? 13'd3 : (r_height > 13'd4096) ? 13'd4096 : r_height;
        w_s = (r_stride == 4'd0) ? 4'd1 : (r_stride > 4'd8) ? 4'd8 : r_stride;
        w_step = {1'b0, r_dil} + 4'd1;
        w_span = 5'd3 + {1'b0, r_dil, 1'b0};
    end

    // pipeline control
    logic w_en, w_acc;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    assign w_en          = !(r_v6 && !m_axis_tready);
    assign w_acc         = w_en && s_axis_tvalid;
    assign s_axis_tready = w_en;

    // position counters
    logic [ROW_W-1:0]  r_row, n_row, r_orow, n_orow;
    logic [COL_W-1:0]  r_col, n_col, r_ocol, n_ocol;
    logic [2:0]        r_rph, n_rph, r_cph, n_cph;
    logic [SLOT_W-1:0] r_wslot, n_wslot, w_rslot0, w_rslot1;
    logic w_row_ok, w_col_ok, w_c_end, w_r_end;
    t_meta w_meta;

    always_comb begin
        w_row_ok = ({1'b0, r_row} + 13'd1) >= {8'd0, w_span};
        w_col_ok = ({1'b0, r_col} + 11'd1) >= {6'd0, w_span};
        w_c_end  = ({1'b0, r_col} + 11'd1) >= w_w;
        w_r_end  = ({1'b0, r_row} + 13'd1) >= w_h;
        w_meta.orow = r_orow;
        w_meta.ocol = r_ocol;
        w_meta.win  = w_row_ok && w_col_ok && r_rph == 3'd0 && r_cph == 3'd0;
        w_meta.last = (({1'b0, r_row} + {9'd0, w_s}) >= w_h)
                   && (({1'b0, r_col} + {7'd0, w_s}) >= w_w);

        // slots of the two earlier kernel rows, modulo the slot count
        w_rslot1 = (r_wslot >= SLOT_W'(w_step)) ? r_wslot - SLOT_W'(w_step)
                 : r_wslot + SLOT_W'(ROW_SLOTS) - SLOT_W'(w_step);
        w_rslot0 = (r_wslot >= SLOT_W'({w_step, 1'b0})) ? r_wslot - SLOT_W'({w_step, 1'b0})
                 : r_wslot + SLOT_W'(ROW_SLOTS) - SLOT_W'({w_step, 1'b0});

        n_row = r_row; n_col = r_col; n_orow = r_orow; n_ocol = r_ocol;
        n_rph = r_rph; n_cph = r_cph; n_wslot = r_wslot;
        if (w_row_ok && w_col_ok) begin
            n_cph = (({1'b0, r_cph} + 4'd1) >= w_s) ? 3'd0 : r_cph + 3'd1;
            if (w_meta.win) begin
                n_ocol = r_ocol + COL_W'(1);
            end
        end
        if (w_c_end) begin
            n_col  = '0;
            n_cph  = '0;
            n_ocol = '0;
            if (w_row_ok) begin
                n_rph = (({1'b0, r_rph} + 4'd1) >= w_s) ? 3'd0 : r_rph + 3'd1;
                if (r_rph == 3'd0) begin
                    n_orow = r_orow + ROW_W'(1);
                end
            end
            if (w_r_end) begin
                n_row   = '0;
                n_rph   = '0;
                n_orow  = '0;
                n_wslot = '0;
            end else begin
                n_row   = r_row + ROW_W'(1);
                n_wslot = (r_wslot == SLOT_W'(ROW_SLOTS - 1)) ? '0 : r_wslot + SLOT_W'(1);
            end
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_row <= '0; r_col <= '0; r_orow <= '0; r_ocol <= '0;
            r_rph <= '0; r_cph <= '0; r_wslot <= '0;
        end else if (w_acc) begin
            r_row <= n_row; r_col <= n_col; r_orow <= n_orow; r_ocol <= n_ocol;
            r_rph <= n_rph; r_cph <= n_cph; r_wslot <= n_wslot;
        end
    end

    // line memory: one write, two registered reads
    logic [7:0] r_mem [0:MEM_DEPTH-1];
    logic [7:0] r_rd0, r_rd1;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[{r_wslot, r_col}] <= s_axis_tdata;
        end
        if (w_en) begin
            r_rd0 <= r_mem[{w_rslot0, r_col}];
            r_rd1 <= r_mem[{w_rslot1, r_col}];
        end
    end

    // stage registers
    logic [7:0] r_pix1;
    t_meta      r_meta1, r_meta2, r_meta3, r_meta4, r_meta5;
    logic       w_shift;

    assign w_shift = w_en && r_v1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix1  <= s_axis_tdata;
            r_meta1 <= w_meta;
            r_meta2 <= r_meta1;
            r_meta3 <= r_meta2;
            r_meta4 <= r_meta3;
            r_meta5 <= r_meta4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_meta2.win;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // three kernel rows, top row first
    logic signed [SUM_W-1:0] w_rsum [0:2];

    sdc_row u_row0 (.i_clk(i_clk), .i_en(w_en), .i_shift(w_shift), .i_pix(r_rd0),
                    .i_step(w_step), .i_coef(r_coef[0]), .o_sum(w_rsum[0]));
    sdc_row u_row1 (.i_clk(i_clk), .i_en(w_en), .i_shift(w_shift), .i_pix(r_rd1),
                    .i_step(w_step), .i_coef(r_coef[1]), .o_sum(w_rsum[1]));
    sdc_row u_row2 (.i_clk(i_clk), .i_en(w_en), .i_shift(w_shift), .i_pix(r_pix1),
                    .i_step(w_step), .i_coef(r_coef[2]), .o_sum(w_rsum[2]));

    logic signed [SUM_W-1:0] r_sum5, r_sum6;
    logic [7:0]  r_pout6, w_pout;
    t_meta       r_meta6;
    logic [19:0] w_q;
    logic [20:0] w_qr;
    logic        w_inc;

    // round half to even, clamp to 0..255
    always_comb begin
        w_q   = r_sum5[SUM_W-1:8];
        w_inc = (r_sum5[7:0] > 8'd128) || (r_sum5[7:0] == 8'd128 && w_q[0]);
        w_qr  = {1'b0, w_q} + {20'd0, w_inc};
        if (r_sum5[SUM_W-1] || r_sum5 == '0) begin
            w_pout = 8'd0;
        end else if (w_qr > 21'd255) begin
            w_pout = 8'd255;
        end else begin
            w_pout = w_qr[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum5  <= w_rsum[0] + w_rsum[1] + w_rsum[2];
            r_sum6  <= r_sum5;
            r_pout6 <= w_pout;
            r_meta6 <= r_meta5;
        end
    end

    assign m_axis_tvalid = r_v6;
    assign m_axis_tdata  = {6'd0, r_pout6, r_sum6, r_meta6.ocol, r_meta6.orow};
    assign m_axis_tlast  = r_meta6.last;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < w_w) else $error("column counter past row end");
    a_row_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rph} < w_s) else $error("row phase past stride");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot < SLOT_W'(ROW_SLOTS)) else $error("line slot out of range");
    a_win_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_meta.win) |-> w_row_ok && w_col_ok)
        else $error("window before span filled");
`endif
endmodule
`default_nettype wire
